// File: rtl/mrnlms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mrnlms_pkg
// Shared types and constants of the three-reference NLMS noise canceller.
// ============================================================================
package mrnlms_pkg;

    localparam int DEF_TAPS      = 8;
    localparam int CHANNELS      = 3;
    localparam int SAMPLE_W      = 16;
    localparam int WEIGHT_W      = 32;
    localparam int STEP_W        = 16;
    localparam int STEP_ERR_W    = 32;
    // mu*|err|*|tap| scaled by 2^12
    localparam int NUM_W         = 60;
    localparam int NUM_CNT_W     = 6;
    localparam int ADDR_W        = 3;
    localparam logic [15:0] STEP_RESET = 16'd328;
    // Register index taken from paddr[2].
    localparam logic REG_STEP_SIZE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_MERGE,
        S_ERR,
        S_MU,
        S_UPD
    } top_state_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_ADD
    } lane_state_t;

    typedef struct packed {
        logic                       shift_en;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       mac_en;
        logic                       upd_start;
        logic                       err_neg;
        logic [STEP_ERR_W-1:0]      step_err;
    } lane_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/mrnlms_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mrnlms_lane
// One reference channel: tap line, weights, dot product and energy pass, and
// the weight update with its own serial restoring divider.
// ============================================================================
module mrnlms_lane #(
    parameter int TAPS = mrnlms_pkg::DEF_TAPS,
    localparam int AW  = 48 + $clog2(TAPS) + 1,
    localparam int EW  = 31 + $clog2(TAPS),
    localparam int DW  = EW + 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrnlms_pkg::lane_ctrl_t ctrl,
    input  logic [DW-1:0]          den,
    output logic signed [AW-1:0]   acc,
    output logic [EW-1:0]          energy,
    output logic                   busy
);
    import mrnlms_pkg::*;

    localparam int CW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SW = NUM_W + 2;
    localparam logic [CW-1:0] LAST_TAP = CW'(TAPS - 1);
    localparam logic [NUM_CNT_W-1:0] LAST_STEP = NUM_CNT_W'(NUM_W - 1);

    logic signed [SAMPLE_W-1:0] tap_reg [TAPS];
    logic signed [WEIGHT_W-1:0] wgt_reg [TAPS];
    logic signed [AW-1:0]       acc_reg;
    logic [EW-1:0]              energy_reg;
    logic                       prod_vld_reg;
    logic signed [47:0]         prod_reg;
    logic [30:0]                sq_reg;
    lane_state_t                state_reg, state_next;
    logic [CW-1:0]              tap_cnt_reg, tap_cnt_next;
    logic [NUM_CNT_W-1:0]       step_cnt_reg, step_cnt_next;
    logic [NUM_W-1:0]           num_reg;
    logic [DW-1:0]              rem_reg;
    logic                       neg_reg;

    logic [SAMPLE_W-1:0]        tap_mag;
    logic [DW:0]                trial;
    logic                       q_bit;
    logic signed [SW-1:0]       delta;
    logic signed [SW-1:0]       wsum;
    logic signed [WEIGHT_W-1:0] wgt_next;

    assign tap_mag = tap_reg[0][SAMPLE_W-1] ? SAMPLE_W'(-tap_reg[0]) : tap_reg[0];
    assign trial   = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit   = (trial >= {1'b0, den});
    assign delta   = neg_reg ? -$signed({2'b00, num_reg}) : $signed({2'b00, num_reg});
    assign wsum    = SW'(wgt_reg[0]) + delta;

    always_comb
    begin
        if (wsum > SW'(32'sh7FFF_FFFF))
        begin
            wgt_next = 32'sh7FFF_FFFF;
        end
        else if (wsum < -SW'(64'sh8000_0000))
        begin
            wgt_next = 32'sh8000_0000;
        end
        else
        begin
            wgt_next = wsum[WEIGHT_W-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        tap_cnt_next  = tap_cnt_reg;
        step_cnt_next = step_cnt_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (ctrl.upd_start)
                begin
                    state_next   = L_MUL;
                    tap_cnt_next = '0;
                end
            end
            L_MUL:
            begin
                state_next    = L_DIV;
                step_cnt_next = '0;
            end
            L_DIV:
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST_STEP)
                begin
                    state_next = L_ADD;
                end
            end
            L_ADD:
            begin
                tap_cnt_next = tap_cnt_reg + 1'b1;
                state_next   = (tap_cnt_reg == LAST_TAP) ? L_IDLE : L_MUL;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                tap_reg[i] <= '0;
                wgt_reg[i] <= '0;
            end
            acc_reg      <= '0;
            energy_reg   <= '0;
            prod_vld_reg <= 1'b0;
            state_reg    <= L_IDLE;
            tap_cnt_reg  <= '0;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_cnt_reg  <= tap_cnt_next;
            step_cnt_reg <= step_cnt_next;
            prod_vld_reg <= ctrl.mac_en;
            if (ctrl.shift_en)
            begin
                for (int i = TAPS - 1; i > 0; i--)
                begin
                    tap_reg[i] <= tap_reg[i-1];
                end
                tap_reg[0] <= ctrl.sample;
                acc_reg    <= '0;
                energy_reg <= '0;
            end
            else
            begin
                if (prod_vld_reg)
                begin
                    acc_reg    <= acc_reg + AW'(prod_reg);
                    energy_reg <= energy_reg + EW'(sq_reg);
                end
                // Both passes rotate the lines once per tap, so after a full
                // pass every tap sits in its place again.
                if (ctrl.mac_en || state_reg == L_ADD)
                begin
                    for (int i = 0; i < TAPS; i++)
                    begin
                        tap_reg[i] <= tap_reg[(i + 1) % TAPS];
                        wgt_reg[i] <= wgt_reg[(i + 1) % TAPS];
                    end
                    if (state_reg == L_ADD)
                    begin
                        wgt_reg[TAPS-1] <= wgt_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 48'(wgt_reg[0] * tap_reg[0]);
        sq_reg   <= 31'($unsigned(32'(tap_reg[0] * tap_reg[0])));
        if (state_reg == L_MUL)
        begin
            num_reg <= {48'(ctrl.step_err * tap_mag), 12'b0};
            neg_reg <= ctrl.err_neg ^ tap_reg[0][SAMPLE_W-1];
            rem_reg <= '0;
        end
        else if (state_reg == L_DIV)
        begin
            rem_reg <= q_bit ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
        end
    end

    assign acc    = acc_reg;
    assign energy = energy_reg;
    assign busy   = (state_reg != L_IDLE);

endmodule
`default_nettype wire

// File: rtl/multi_reference_nlms_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// multi_reference_nlms_filter
// Three-reference normalized LMS noise canceller, one lane per channel.
// ============================================================================
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | ref_a, ref_b, ref_c, desired
//  output   | out_valid / out_ready| error_out
//  config   | APB write, pready=1  | step_size at byte address 0
//
// A request is taken only in S_IDLE; its time, when out_ready keeps up, is set
// by the serial restoring divider in each lane that handles its taps one after
// another. The error is posted after the MAC pass and the S_DRAIN, S_MERGE and
// S_ERR states, so the weight update overlaps waiting for out_ready.
// Reset clears the taps, the weights and the step size to its default. A full
// output register stalls the block before the weight update begins.
module multi_reference_nlms_filter #(
    parameter int TAPS = mrnlms_pkg::DEF_TAPS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mrnlms_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [mrnlms_pkg::SAMPLE_W-1:0] ref_a,
    input  logic signed [mrnlms_pkg::SAMPLE_W-1:0] ref_b,
    input  logic signed [mrnlms_pkg::SAMPLE_W-1:0] ref_c,
    input  logic signed [mrnlms_pkg::SAMPLE_W-1:0] desired,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [mrnlms_pkg::SAMPLE_W-1:0] error_out
);
    import mrnlms_pkg::*;

    localparam int AW = 48 + $clog2(TAPS) + 1;
    localparam int EW = 31 + $clog2(TAPS);
    localparam int DW = EW + 2;
    localparam int TW = AW + 2;
    localparam int CW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [CW-1:0] LAST_TAP = CW'(TAPS - 1);

    top_state_t                 state_reg, state_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [STEP_W-1:0]          step_reg;
    logic signed [SAMPLE_W-1:0] want_reg;
    logic signed [TW-1:0]       tot_reg;
    logic [DW-1:0]              den_reg;
    logic signed [SAMPLE_W-1:0] err_reg;
    logic [STEP_ERR_W-1:0]      step_err_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    lane_ctrl_t                 ctrl [CHANNELS];
    logic signed [AW-1:0]       lane_acc [CHANNELS];
    logic [EW-1:0]              lane_energy [CHANNELS];
    logic [CHANNELS-1:0]        lane_busy;
    logic signed [SAMPLE_W-1:0] sample [CHANNELS];

    logic                       accept;
    logic                       cfg_write;
    logic                       out_load;
    logic signed [TW-1:0]       estimate;
    logic signed [TW-1:0]       diff;
    logic signed [SAMPLE_W-1:0] err_sat;
    logic [SAMPLE_W-1:0]        err_mag;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_STEP_SIZE);
    assign prdata    = (paddr[2] == REG_STEP_SIZE) ? {16'b0, step_reg} : 32'b0;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == S_ERR) && (!out_valid_reg || out_ready);

    assign sample[0] = ref_a;
    assign sample[1] = ref_b;
    assign sample[2] = ref_c;

    // Arithmetic shift is the floor of the exact sum over 2^27.
    assign estimate = tot_reg >>> 27;
    assign diff     = TW'(want_reg) - estimate;
    assign err_mag  = err_reg[SAMPLE_W-1] ? SAMPLE_W'(-err_reg) : err_reg;

    always_comb
    begin
        if (diff > TW'(32767))
        begin
            err_sat = 16'sh7FFF;
        end
        else if (diff < -TW'(32768))
        begin
            err_sat = 16'sh8000;
        end
        else
        begin
            err_sat = diff[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MAC;
                    cnt_next   = '0;
                end
            end
            S_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_TAP)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                if (out_load)
                begin
                    state_next = S_MU;
                end
            end
            S_MU:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (lane_busy == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            ctrl[c].shift_en  = accept;
            ctrl[c].sample    = sample[c];
            ctrl[c].mac_en    = (state_reg == S_MAC);
            ctrl[c].upd_start = (state_reg == S_MU);
            ctrl[c].err_neg   = err_reg[SAMPLE_W-1];
            ctrl[c].step_err  = step_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= STEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_write)
            begin
                step_reg <= pwdata[STEP_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            want_reg <= desired;
        end
        if (state_reg == S_MERGE)
        begin
            tot_reg <= TW'(lane_acc[0]) + TW'(lane_acc[1]) + TW'(lane_acc[2]);
            den_reg <= DW'(lane_energy[0]) + DW'(lane_energy[1])
                     + DW'(lane_energy[2]) + DW'(1);
        end
        if (state_reg == S_ERR)
        begin
            err_reg <= err_sat;
        end
        if (out_load)
        begin
            out_data_reg <= err_sat;
        end
        if (state_reg == S_MU)
        begin
            step_err_reg <= STEP_ERR_W'(step_reg * err_mag);
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        mrnlms_lane #(
            .TAPS (TAPS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl[c]),
            .den    (den_reg),
            .acc    (lane_acc[c]),
            .energy (lane_energy[c]),
            .busy   (lane_busy[c])
        );
    end

    assign out_valid = out_valid_reg;
    assign error_out = out_data_reg;

`ifndef NO_ASSERTIONS
    a_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (lane_busy == '0))
        else $error("lane busy while a new request is taken");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken before the first finished");

    a_post_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == S_MU))
        else $error("error posted without starting the weight update");
`endif

endmodule
`default_nettype wire
